// ===== hdl/vng_pkg.sv =====
package vng_pkg;

  localparam int DEF_MAX_VERTICES = 4096;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 80;
  localparam int VCOUNT_W    = 13;

  localparam logic [1:0] FUNC_WPOS   = 2'd0;
  localparam logic [1:0] FUNC_TRI    = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_FINISH = 2'd3;

  localparam logic [1:0] ST_OPEN   = 2'd0;
  localparam logic [1:0] ST_GEN    = 2'd1;
  localparam logic [1:0] ST_FAILED = 2'd2;

  typedef logic [4:0] dp_op_t;

  localparam dp_op_t OP_NONE  = 5'd0;
  localparam dp_op_t OP_LATCH = 5'd1;
  localparam dp_op_t OP_WPOS  = 5'd2;
  localparam dp_op_t OP_TBAD  = 5'd3;
  localparam dp_op_t OP_PRD   = 5'd4;
  localparam dp_op_t OP_DIFF  = 5'd5;
  localparam dp_op_t OP_MUL   = 5'd6;
  localparam dp_op_t OP_CROSS = 5'd7;
  localparam dp_op_t OP_IGN   = 5'd8;
  localparam dp_op_t OP_SRD   = 5'd9;
  localparam dp_op_t OP_SWR   = 5'd10;
  localparam dp_op_t OP_VRD   = 5'd11;
  localparam dp_op_t OP_VCAP  = 5'd12;
  localparam dp_op_t OP_FB    = 5'd13;
  localparam dp_op_t OP_SHIFT = 5'd14;
  localparam dp_op_t OP_SQ    = 5'd15;
  localparam dp_op_t OP_L2    = 5'd16;
  localparam dp_op_t OP_SQRT  = 5'd17;
  localparam dp_op_t OP_DINIT = 5'd18;
  localparam dp_op_t OP_DSTEP = 5'd19;
  localparam dp_op_t OP_DEND  = 5'd20;
  localparam dp_op_t OP_WINIT = 5'd21;
  localparam dp_op_t OP_WRD   = 5'd22;
  localparam dp_op_t OP_GOOD  = 5'd23;
  localparam dp_op_t OP_FAIL  = 5'd24;
  localparam dp_op_t OP_RES   = 5'd25;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] sel;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] run_status;
    logic       bad_corner;
    logic       vi_ok;
    logic       live_zero;
    logic       zero_cross;
    logic       sum_zero;
    logic       shift_ok;
    logic       walk_nz;
    logic       walk_last;
  } dp_stat_t;

endpackage

// ===== hdl/vng_datapath.sv =====
module vng_datapath
  import vng_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic [1:0]             in_func,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic                   cfg_we,
  input  logic [VCOUNT_W-1:0]    cfg_data,
  output logic [VCOUNT_W-1:0]    vertex_count,
  output logic [OUT_TDATA_W-1:0] out_data,
  output logic                   out_fb
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int KW = (CW > 16) ? CW : 16;
  localparam int VW = (CW > VCOUNT_W) ? CW : VCOUNT_W;

  logic [1:0]  func;
  logic [11:0] vi;
  logic signed [23:0] in_px, in_py, in_pz;
  logic [15:0] corner [3];

  logic [1:0]  run_status;
  logic [23:0] ignored;
  logic [CW-1:0] live;
  logic [CW-1:0] widx;

  logic [71:0]  pos_mem [MAX_VERTICES];
  logic [191:0] sum_mem [MAX_VERTICES];
  logic [71:0]  pos_q;
  logic [191:0] sum_q;
  logic [AW-1:0] pos_ra, sum_ra, sum_wa;
  logic          pos_we, sum_we;
  logic [191:0]  sum_wd;

  logic       pcap_v;
  logic [1:0] pcap_sel;
  logic signed [23:0] px [3];
  logic signed [23:0] py [3];
  logic signed [23:0] pz [3];
  logic signed [24:0] abx, aby, abz, acx, acy, acz;
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod [6];
  logic signed [50:0] nx, ny, nz;

  logic [63:0] m [3];
  logic [2:0]  neg;
  logic        szero;
  logic        hi_any, b30_any;
  logic [61:0] sq [3];
  logic [63:0] srem, sres, sbit, st;
  logic [46:0] dvd, dq;
  logic [31:0] drem;
  logic [32:0] dt;
  logic [15:0] dclamp;
  logic [15:0] nrm [3];
  logic        fb;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] s,
                                                  input logic signed [50:0] n);
    logic signed [64:0] t;
    t = 65'(s) + 65'(n);
    if (t[64] != t[63]) begin
      return t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return t[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] s);
    return s[63] ? (64'd0 - s) : s;
  endfunction

  always_comb begin
    if (VW'(vertex_count) < VW'(MAX_VERTICES)) begin
      live = CW'(vertex_count);
    end else begin
      live = CW'(MAX_VERTICES);
    end
  end

  assign stat.func       = func;
  assign stat.run_status = run_status;
  assign stat.bad_corner = (KW'(corner[0]) >= KW'(live)) || (KW'(corner[1]) >= KW'(live)) ||
                           (KW'(corner[2]) >= KW'(live));
  assign stat.vi_ok      = KW'(vi) < KW'(live);
  assign stat.live_zero  = (live == '0);
  assign stat.zero_cross = (nx == '0) && (ny == '0) && (nz == '0);
  assign stat.sum_zero   = szero;
  assign hi_any  = |{m[0][63:31], m[1][63:31], m[2][63:31]};
  assign b30_any = m[0][30] | m[1][30] | m[2][30];
  assign stat.shift_ok   = !hi_any && b30_any;
  // The sum read by the walk is checked in the cycle its read data arrives.
  assign stat.walk_nz    = (sum_q != '0);
  assign stat.walk_last  = (widx == live);

  // Memory address and write selection.
  assign pos_ra = AW'(corner[cmd.sel]);
  always_comb begin
    case (cmd.op)
      OP_VRD:  sum_ra = AW'(vi);
      OP_WRD:  sum_ra = AW'(widx);
      default: sum_ra = AW'(corner[cmd.sel]);
    endcase
  end
  assign pos_we = (cmd.op == OP_WPOS) && (run_status == ST_OPEN) &&
                  (KW'(vi) < KW'(MAX_VERTICES));
  assign sum_we = pos_we || (cmd.op == OP_SWR);
  assign sum_wa = (cmd.op == OP_SWR) ? AW'(corner[cmd.sel]) : AW'(vi);
  assign sum_wd = (cmd.op == OP_SWR) ?
                  {sat_add(sum_q[191:128], nz), sat_add(sum_q[127:64], ny),
                   sat_add(sum_q[63:0], nx)} : 192'd0;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[AW'(vi)] <= {in_pz, in_py, in_px};
    end
    pos_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_wa] <= sum_wd;
    end
    sum_q <= sum_mem[sum_ra];
  end

  // Shared product operands for the six cross-product terms.
  always_comb begin
    case (cmd.idx)
      3'd0:    begin mul_a = aby; mul_b = acz; end
      3'd1:    begin mul_a = abz; mul_b = acy; end
      3'd2:    begin mul_a = abz; mul_b = acx; end
      3'd3:    begin mul_a = abx; mul_b = acz; end
      3'd4:    begin mul_a = abx; mul_b = acy; end
      default: begin mul_a = aby; mul_b = acx; end
    endcase
  end

  assign st     = sres + sbit;
  assign dt     = {drem, dvd[46]};
  assign dclamp = (dq > 47'd32767) ? 16'd32767 : dq[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      ignored      <= '0;
      run_status   <= ST_OPEN;
      pcap_v       <= 1'b0;
    end else begin
      pcap_v <= (cmd.op == OP_PRD);
      if (cfg_we) begin
        vertex_count <= cfg_data;
        ignored      <= '0;
        run_status   <= ST_OPEN;
      end
      case (cmd.op)
        OP_TBAD, OP_FAIL: run_status <= ST_FAILED;
        OP_GOOD:          run_status <= ST_GEN;
        OP_IGN: begin
          if (ignored != 24'hFFFFFF) begin
            ignored <= ignored + 24'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pcap_sel <= cmd.sel;
    if (pcap_v) begin
      px[pcap_sel] <= pos_q[23:0];
      py[pcap_sel] <= pos_q[47:24];
      pz[pcap_sel] <= pos_q[71:48];
    end
    case (cmd.op)
      OP_LATCH: begin
        func      <= in_func;
        vi        <= in_data[11:0];
        in_px     <= in_data[35:12];
        in_py     <= in_data[59:36];
        in_pz     <= in_data[83:60];
        corner[0] <= in_data[99:84];
        corner[1] <= in_data[115:100];
        corner[2] <= in_data[131:116];
        nrm[0]    <= '0;
        nrm[1]    <= '0;
        nrm[2]    <= '0;
        fb        <= 1'b0;
      end
      OP_DIFF: begin
        abx <= 25'(px[1]) - 25'(px[0]);
        aby <= 25'(py[1]) - 25'(py[0]);
        abz <= 25'(pz[1]) - 25'(pz[0]);
        acx <= 25'(px[2]) - 25'(px[0]);
        acy <= 25'(py[2]) - 25'(py[0]);
        acz <= 25'(pz[2]) - 25'(pz[0]);
      end
      OP_MUL: prod[cmd.idx] <= mul_a * mul_b;
      OP_CROSS: begin
        nx <= 51'(prod[0]) - 51'(prod[1]);
        ny <= 51'(prod[2]) - 51'(prod[3]);
        nz <= 51'(prod[4]) - 51'(prod[5]);
      end
      OP_VCAP: begin
        m[0]  <= mag(sum_q[63:0]);
        m[1]  <= mag(sum_q[127:64]);
        m[2]  <= mag(sum_q[191:128]);
        neg   <= {sum_q[191], sum_q[127], sum_q[63]};
        szero <= (sum_q == '0);
      end
      OP_FB: begin
        nrm[1] <= 16'd32767;
        fb     <= 1'b1;
      end
      OP_SHIFT: begin
        if (hi_any) begin
          m[0] <= m[0] >> 1;
          m[1] <= m[1] >> 1;
          m[2] <= m[2] >> 1;
        end else if (!b30_any) begin
          m[0] <= m[0] << 1;
          m[1] <= m[1] << 1;
          m[2] <= m[2] << 1;
        end
      end
      OP_SQ: sq[cmd.idx[1:0]] <= m[cmd.idx[1:0]][30:0] * m[cmd.idx[1:0]][30:0];
      OP_L2: begin
        srem <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
        sres <= '0;
        sbit <= 64'd1 << 62;
      end
      OP_SQRT: begin
        if (srem >= st) begin
          srem <= srem - st;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      OP_DINIT: begin
        dvd  <= 47'({m[cmd.sel][30:0], 15'd0}) - 47'(m[cmd.sel][30:0]) + 47'(sres[31:1]);
        drem <= '0;
        dq   <= '0;
      end
      OP_DSTEP: begin
        dvd <= dvd << 1;
        if (dt >= {1'b0, sres[31:0]}) begin
          drem <= 32'(dt - {1'b0, sres[31:0]});
          dq   <= {dq[45:0], 1'b1};
        end else begin
          drem <= dt[31:0];
          dq   <= {dq[45:0], 1'b0};
        end
      end
      OP_DEND: nrm[cmd.sel] <= neg[cmd.sel] ? (16'd0 - dclamp) : dclamp;
      OP_WINIT: widx <= '0;
      OP_WRD:   widx <= widx + 1'b1;
      OP_RES: begin
        out_data <= {6'd0, ignored, run_status, nrm[2], nrm[1], nrm[0]};
        out_fb   <= fb;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/vng_controller.sv =====
module vng_controller
  import vng_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_PRA   = 5'd2;
  localparam logic [4:0] S_PRB   = 5'd3;
  localparam logic [4:0] S_PRC   = 5'd4;
  localparam logic [4:0] S_PWAIT = 5'd5;
  localparam logic [4:0] S_DIFF  = 5'd6;
  localparam logic [4:0] S_MUL   = 5'd7;
  localparam logic [4:0] S_CROSS = 5'd8;
  localparam logic [4:0] S_CHK   = 5'd9;
  localparam logic [4:0] S_SRD   = 5'd10;
  localparam logic [4:0] S_SWR   = 5'd11;
  localparam logic [4:0] S_VRD   = 5'd12;
  localparam logic [4:0] S_VCAP  = 5'd13;
  localparam logic [4:0] S_VCHK  = 5'd14;
  localparam logic [4:0] S_SHIFT = 5'd15;
  localparam logic [4:0] S_SQ    = 5'd16;
  localparam logic [4:0] S_L2    = 5'd17;
  localparam logic [4:0] S_SQRT  = 5'd18;
  localparam logic [4:0] S_DINIT = 5'd19;
  localparam logic [4:0] S_DSTEP = 5'd20;
  localparam logic [4:0] S_DEND  = 5'd21;
  localparam logic [4:0] S_WRD   = 5'd22;
  localparam logic [4:0] S_WCHK  = 5'd23;
  localparam logic [4:0] S_RES   = 5'd24;

  localparam logic [5:0] MUL_LAST   = 6'd5;
  localparam logic [5:0] SQ_LAST    = 6'd2;
  localparam logic [5:0] SQRT_LAST  = 6'd31;
  localparam logic [5:0] DSTEP_LAST = 6'd46;

  logic [4:0] state, state_next;
  logic [5:0] idx, idx_next;
  logic [1:0] k, k_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    k_next     = k;
    cmd.op     = OP_NONE;
    cmd.sel    = k;
    cmd.idx    = idx[2:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        idx_next   = '0;
        k_next     = '0;
        state_next = S_RES;
        case (stat.func)
          FUNC_WPOS: cmd.op = OP_WPOS;
          FUNC_TRI: begin
            if (stat.run_status == ST_OPEN) begin
              if (stat.bad_corner) begin
                cmd.op = OP_TBAD;
              end else begin
                state_next = S_PRA;
              end
            end
          end
          FUNC_READ: begin
            if (stat.run_status == ST_GEN && stat.vi_ok) begin
              state_next = S_VRD;
            end
          end
          default: begin
            if (stat.run_status == ST_OPEN) begin
              if (stat.live_zero) begin
                cmd.op = OP_FAIL;
              end else begin
                cmd.op     = OP_WINIT;
                state_next = S_WRD;
              end
            end
          end
        endcase
      end
      S_PRA: begin
        cmd.op = OP_PRD; cmd.sel = 2'd0; state_next = S_PRB;
      end
      S_PRB: begin
        cmd.op = OP_PRD; cmd.sel = 2'd1; state_next = S_PRC;
      end
      S_PRC: begin
        cmd.op = OP_PRD; cmd.sel = 2'd2; state_next = S_PWAIT;
      end
      S_PWAIT: state_next = S_DIFF;
      S_DIFF: begin
        cmd.op = OP_DIFF; state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        if (idx == MUL_LAST) begin
          idx_next = '0; state_next = S_CROSS;
        end else begin
          idx_next = idx + 6'd1;
        end
      end
      S_CROSS: begin
        cmd.op = OP_CROSS; state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.zero_cross) begin
          cmd.op = OP_IGN; state_next = S_RES;
        end else begin
          state_next = S_SRD;
        end
      end
      S_SRD: begin
        cmd.op = OP_SRD; state_next = S_SWR;
      end
      S_SWR: begin
        cmd.op = OP_SWR;
        if (k == 2'd2) begin
          state_next = S_RES;
        end else begin
          k_next = k + 2'd1; state_next = S_SRD;
        end
      end
      S_VRD: begin
        cmd.op = OP_VRD; state_next = S_VCAP;
      end
      S_VCAP: begin
        cmd.op = OP_VCAP; state_next = S_VCHK;
      end
      S_VCHK: begin
        if (stat.sum_zero) begin
          cmd.op = OP_FB; state_next = S_RES;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_ok) begin
          state_next = S_SQ;
        end else begin
          cmd.op = OP_SHIFT;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (idx == SQ_LAST) begin
          idx_next = '0; state_next = S_L2;
        end else begin
          idx_next = idx + 6'd1;
        end
      end
      S_L2: begin
        cmd.op = OP_L2; state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (idx == SQRT_LAST) begin
          idx_next = '0; state_next = S_DINIT;
        end else begin
          idx_next = idx + 6'd1;
        end
      end
      S_DINIT: begin
        cmd.op = OP_DINIT; state_next = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = OP_DSTEP;
        if (idx == DSTEP_LAST) begin
          idx_next = '0; state_next = S_DEND;
        end else begin
          idx_next = idx + 6'd1;
        end
      end
      S_DEND: begin
        cmd.op = OP_DEND;
        if (k == 2'd2) begin
          state_next = S_RES;
        end else begin
          k_next = k + 2'd1; state_next = S_DINIT;
        end
      end
      S_WRD: begin
        cmd.op = OP_WRD; state_next = S_WCHK;
      end
      S_WCHK: begin
        if (stat.walk_nz) begin
          cmd.op = OP_GOOD; state_next = S_RES;
        end else if (stat.walk_last) begin
          cmd.op = OP_FAIL; state_next = S_RES;
        end else begin
          state_next = S_WRD;
        end
      end
      S_RES: begin
        if (out_free) begin
          cmd.op = OP_RES; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      k     <= k_next;
      if (state == S_RES && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/vertex_normal_generator.sv =====
// Area-weighted vertex normal generator.
// Input words arrive on the s_axis channel: tuser carries the function code
// (write position, triangle, read normal, finish) and tdata the vertex index,
// the Q16.8 position and the three triangle corners. Every input word yields
// exactly one output word on m_axis carrying the Q1.15 normal, the run status
// and the count of ignored zero-area triangles; tuser flags the (0,1,0)
// fallback. The APB port holds the vertex count; writing it starts a new run.
// Words are processed one at a time by a sequencer over one-read-one-write
// position and sum memories and a shared 25x25 multiplier. A triangle that
// updates the sums takes three position reads, six products and three
// read-modify-writes of the sums; a normal read of a nonzero sum takes up to
// 33 normalizing shifts, a 32-step square root and three 47-step dividers;
// finish walks the vertices. The next word is accepted as soon as a result
// is registered, even if the receiver has not yet taken it; a stalled
// receiver then blocks only the completion of the following word.
// Synchronous reset clears the vertex count, status and ignored count;
// memory contents are not cleared.
module vertex_normal_generator
  import vng_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // normal_x, normal_y, normal_z, status, ignored_triangles, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // used_fallback
  output logic                   m_axis_tuser,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic                 cfg_we;
  logic [VCOUNT_W-1:0]  vertex_count;

  // Only the vertex count register exists, at byte addresses 0 to 3 (paddr[2] low).
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(vertex_count);

  vng_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vng_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_func      (s_axis_tuser),
    .in_data      (s_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_data     (pwdata[VCOUNT_W-1:0]),
    .vertex_count (vertex_count),
    .out_data     (m_axis_tdata),
    .out_fb       (m_axis_tuser)
  );

endmodule
